// ===== src/vrce_pkg.sv =====
// ----------------------------------------------------------------------------
// vrce_pkg
// Shared widths, types, register indexes and helpers for the route cost
// evaluator.
// ----------------------------------------------------------------------------
package vrce_pkg;

  // Field and accumulator widths.
  localparam int TIME_BITS   = 20;
  localparam int TOTAL_BITS  = 40;
  localparam int COST_BITS   = TOTAL_BITS + 2;
  localparam int DEMAND_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CAP_BITS    = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = CAP_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_VEHICLE_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPOT_DUE_TIME   = 1'b1;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [TIME_BITS+1:0]   time_sum_t;
  typedef logic [TOTAL_BITS-1:0]  total_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [DEMAND_BITS-1:0] demand_t;
  typedef logic [CAP_BITS-1:0]    cap_t;

  // One visit as held in the input stage.
  typedef struct packed {
    demand_t demand;
    time_t   service_time;
    time_t   ready_time;
    time_t   due_time;
    time_t   travel_in;
    time_t   travel_home;
    logic    route_start;
    logic    route_end;
    logic    solution_end;
  } visit_t;

  // Configuration seen by the route core.
  typedef struct packed {
    cap_t  vehicle_capacity;
    time_t depot_due_time;
  } cfg_t;

  // Solution totals handed to the output register.
  typedef struct packed {
    total_t total_distance;
    total_t total_wait;
    total_t total_time_warp;
    total_t total_capacity_excess;
    count_t route_count;
  } totals_t;

  // Add that clamps at all ones of the accumulator width.
  function automatic total_t sat_add(input total_t a, input total_t b);
    logic [TOTAL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
  endfunction

endpackage

// ===== src/vrce_in_if.sv =====
// ----------------------------------------------------------------------------
// vrce_in_if
// Visit channel: one beat carries one client visit in route order.
// ----------------------------------------------------------------------------
interface vrce_in_if import vrce_pkg::*; ();

  logic    valid;
  logic    ready;
  demand_t demand;
  time_t   service_time;
  time_t   ready_time;
  time_t   due_time;
  time_t   travel_in;
  time_t   travel_home;
  logic    route_start;
  logic    route_end;
  logic    solution_end;

  modport source (
    output valid, demand, service_time, ready_time, due_time, travel_in,
           travel_home, route_start, route_end, solution_end,
    input  ready
  );

  modport sink (
    input  valid, demand, service_time, ready_time, due_time, travel_in,
           travel_home, route_start, route_end, solution_end,
    output ready
  );

endinterface

// ===== src/vrce_out_if.sv =====
// ----------------------------------------------------------------------------
// vrce_out_if
// Result channel: one beat carries the totals of one finished solution.
// ----------------------------------------------------------------------------
interface vrce_out_if import vrce_pkg::*; ();

  logic                 valid;
  logic                 ready;
  total_t               total_distance;
  total_t               total_wait;
  total_t               total_time_warp;
  total_t               total_capacity_excess;
  count_t               route_count;
  logic [COST_BITS-1:0] penalized_cost;
  logic                 feasible;

  modport source (
    output valid, total_distance, total_wait, total_time_warp,
           total_capacity_excess, route_count, penalized_cost, feasible,
    input  ready
  );

  modport sink (
    input  valid, total_distance, total_wait, total_time_warp,
           total_capacity_excess, route_count, penalized_cost, feasible,
    output ready
  );

endinterface

// ===== src/vrptw_route_cost_evaluator.sv =====
// Flow: a visit beat is registered in the input stage and is evaluated by the
// route core as it leaves that stage; a solution result is then registered in
// the result register. Throughput: one visit per cycle, set by the route core loop, while no visit is stalled.
// A pending result stalls only a following solution-end visit.
// Reset (synchronous, rst_n low) clears all route and solution totals,
// sets vehicle_capacity to zero and depot_due_time to all ones.
// ----------------------------------------------------------------------------
// vrptw_route_cost_evaluator
// Evaluates a time-window routing solution visit by visit and emits the
// totals, penalized cost and feasibility flag at the end of each solution.
// ----------------------------------------------------------------------------
module vrptw_route_cost_evaluator import vrce_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  vrce_in_if.sink                  in_vis,
  vrce_out_if.source               out_res
);

  // Configuration registers.
  cap_t  vehicle_capacity_r;
  time_t depot_due_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vehicle_capacity_r <= '0;
      depot_due_time_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VEHICLE_CAPACITY: vehicle_capacity_r <= cfg_wdata[CAP_BITS-1:0];
        CFG_DEPOT_DUE_TIME:   depot_due_time_r   <= cfg_wdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input stage.
  logic    s1_valid_r;
  visit_t  s1_visit_r;
  logic    s1_adv;
  logic    in_fire;
  logic    out_valid_r;
  totals_t out_totals_r;
  totals_t core_totals;
  logic    core_totals_valid;
  cfg_t    cfg;

  // A visit moves on unless it closes a solution and the result slot is full and not being taken.
  assign s1_adv = s1_valid_r
                  && (!s1_visit_r.solution_end || !out_valid_r || out_res.ready);
  assign in_vis.ready = !s1_valid_r || s1_adv;
  assign in_fire      = in_vis.valid && in_vis.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_visit_r.demand       <= in_vis.demand;
      s1_visit_r.service_time <= in_vis.service_time;
      s1_visit_r.ready_time   <= in_vis.ready_time;
      s1_visit_r.due_time     <= in_vis.due_time;
      s1_visit_r.travel_in    <= in_vis.travel_in;
      s1_visit_r.travel_home  <= in_vis.travel_home;
      s1_visit_r.route_start  <= in_vis.route_start;
      s1_visit_r.route_end    <= in_vis.route_end;
      s1_visit_r.solution_end <= in_vis.solution_end;
    end
  end

  // Route evaluation.
  assign cfg.vehicle_capacity = vehicle_capacity_r;
  assign cfg.depot_due_time   = depot_due_time_r;

  vrce_route_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_adv),
    .visit        (s1_visit_r),
    .cfg          (cfg),
    .totals       (core_totals),
    .totals_valid (core_totals_valid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_totals_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_totals_valid) begin
      out_totals_r <= core_totals;
    end
  end

  // Cost and feasibility come from the registered totals.
  assign out_res.valid                 = out_valid_r;
  assign out_res.total_distance        = out_totals_r.total_distance;
  assign out_res.total_wait            = out_totals_r.total_wait;
  assign out_res.total_time_warp       = out_totals_r.total_time_warp;
  assign out_res.total_capacity_excess = out_totals_r.total_capacity_excess;
  assign out_res.route_count           = out_totals_r.route_count;
  assign out_res.penalized_cost =
      COST_BITS'(out_totals_r.total_distance)
    + COST_BITS'(out_totals_r.total_capacity_excess)
    + COST_BITS'(out_totals_r.total_time_warp)
    + COST_BITS'(out_totals_r.total_wait);
  assign out_res.feasible = (out_totals_r.total_capacity_excess == '0)
                         && (out_totals_r.total_time_warp == '0);

endmodule

// ===== src/vrce_route_core.sv =====
// ----------------------------------------------------------------------------
// vrce_route_core
// Per-route and per-solution accumulators. Evaluates one visit per cycle in which step is high:
// arrival time, waiting, time warp, load and, on the last visit of a route,
// the return leg and the fold into the solution totals.
// ----------------------------------------------------------------------------
module vrce_route_core import vrce_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  visit_t  visit,
  input  cfg_t    cfg,
  output totals_t totals,
  output logic    totals_valid
);

  // Route state.
  total_t route_distance_r, route_distance_nxt;
  total_t route_load_r,     route_load_nxt;
  time_t  clock_time_r,     clock_time_nxt;
  time_t  prev_service_r,   prev_service_nxt;
  total_t route_wait_r,     route_wait_nxt;
  total_t route_warp_r,     route_warp_nxt;

  // Solution state.
  total_t sum_distance_r, sum_distance_nxt;
  total_t sum_wait_r,     sum_wait_nxt;
  total_t sum_warp_r,     sum_warp_nxt;
  total_t sum_excess_r,   sum_excess_nxt;
  count_t routes_seen_r,  routes_seen_nxt;

  // Working values.
  total_t    dist_base, load_base, wait_base, warp_base;
  time_sum_t t_arr, t_home;
  logic      early, late, late_home;
  time_t     t_fin;
  total_t    dist1, load1, wait1, warp1, dist2, warp2;
  total_t    cap_ext;
  total_t    sum_distance_f, sum_wait_f, sum_warp_f, sum_excess_f;
  count_t    routes_f;

  always_comb begin
    // A route start drops whatever route was open.
    dist_base = visit.route_start ? '0 : route_distance_r;
    load_base = visit.route_start ? '0 : route_load_r;
    wait_base = visit.route_start ? '0 : route_wait_r;
    warp_base = visit.route_start ? '0 : route_warp_r;

    // Arrival time; the clock never exceeds the time range, so no clamp.
    if (visit.route_start) begin
      t_arr = time_sum_t'(visit.travel_in);
    end else begin
      t_arr = time_sum_t'(clock_time_r) + time_sum_t'(prev_service_r)
            + time_sum_t'(visit.travel_in);
    end

    dist1 = sat_add(dist_base, total_t'(visit.travel_in));
    load1 = sat_add(load_base, total_t'(visit.demand));

    // Early and late are exclusive; early wins.
    early = t_arr < time_sum_t'(visit.ready_time);
    late  = !early && (t_arr > time_sum_t'(visit.due_time));

    // Waiting before the first client is not counted.
    if (early && !visit.route_start) begin
      wait1 = sat_add(wait_base, total_t'(time_sum_t'(visit.ready_time) - t_arr));
    end else begin
      wait1 = wait_base;
    end

    if (late) begin
      warp1 = sat_add(warp_base, total_t'(t_arr - time_sum_t'(visit.due_time)));
    end else begin
      warp1 = warp_base;
    end

    if (early) begin
      t_fin = visit.ready_time;
    end else if (late) begin
      t_fin = visit.due_time;
    end else begin
      t_fin = t_arr[TIME_BITS-1:0];
    end

    // Return leg to the depot.
    dist2     = sat_add(dist1, total_t'(visit.travel_home));
    t_home    = time_sum_t'(t_fin) + time_sum_t'(visit.service_time)
              + time_sum_t'(visit.travel_home);
    late_home = t_home > time_sum_t'(cfg.depot_due_time);
    if (late_home) begin
      warp2 = sat_add(warp1, total_t'(t_home - time_sum_t'(cfg.depot_due_time)));
    end else begin
      warp2 = warp1;
    end

    // Fold a closed route into the solution totals.
    cap_ext        = total_t'(cfg.vehicle_capacity);
    sum_distance_f = sum_distance_r;
    sum_wait_f     = sum_wait_r;
    sum_warp_f     = sum_warp_r;
    sum_excess_f   = sum_excess_r;
    routes_f       = routes_seen_r;
    if (visit.route_end) begin
      sum_distance_f = sat_add(sum_distance_r, dist2);
      sum_wait_f     = sat_add(sum_wait_r, wait1);
      sum_warp_f     = sat_add(sum_warp_r, warp2);
      if (load1 > cap_ext) begin
        sum_excess_f = sat_add(sum_excess_r, load1 - cap_ext);
      end
      if (routes_seen_r != {COUNT_BITS{1'b1}}) begin
        routes_f = routes_seen_r + count_t'(1);
      end
    end
  end

  // Next state.
  always_comb begin
    route_distance_nxt = route_distance_r;
    route_load_nxt     = route_load_r;
    clock_time_nxt     = clock_time_r;
    prev_service_nxt   = prev_service_r;
    route_wait_nxt     = route_wait_r;
    route_warp_nxt     = route_warp_r;
    sum_distance_nxt   = sum_distance_r;
    sum_wait_nxt       = sum_wait_r;
    sum_warp_nxt       = sum_warp_r;
    sum_excess_nxt     = sum_excess_r;
    routes_seen_nxt    = routes_seen_r;
    if (step) begin
      if (visit.route_end || visit.solution_end) begin
        route_distance_nxt = '0;
        route_load_nxt     = '0;
        clock_time_nxt     = '0;
        prev_service_nxt   = '0;
        route_wait_nxt     = '0;
        route_warp_nxt     = '0;
      end else begin
        route_distance_nxt = dist1;
        route_load_nxt     = load1;
        clock_time_nxt     = t_fin;
        prev_service_nxt   = visit.service_time;
        route_wait_nxt     = wait1;
        route_warp_nxt     = warp1;
      end
      if (visit.solution_end) begin
        sum_distance_nxt = '0;
        sum_wait_nxt     = '0;
        sum_warp_nxt     = '0;
        sum_excess_nxt   = '0;
        routes_seen_nxt  = '0;
      end else begin
        sum_distance_nxt = sum_distance_f;
        sum_wait_nxt     = sum_wait_f;
        sum_warp_nxt     = sum_warp_f;
        sum_excess_nxt   = sum_excess_f;
        routes_seen_nxt  = routes_f;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_distance_r <= '0;
      route_load_r     <= '0;
      clock_time_r     <= '0;
      prev_service_r   <= '0;
      route_wait_r     <= '0;
      route_warp_r     <= '0;
      sum_distance_r   <= '0;
      sum_wait_r       <= '0;
      sum_warp_r       <= '0;
      sum_excess_r     <= '0;
      routes_seen_r    <= '0;
    end else begin
      route_distance_r <= route_distance_nxt;
      route_load_r     <= route_load_nxt;
      clock_time_r     <= clock_time_nxt;
      prev_service_r   <= prev_service_nxt;
      route_wait_r     <= route_wait_nxt;
      route_warp_r     <= route_warp_nxt;
      sum_distance_r   <= sum_distance_nxt;
      sum_wait_r       <= sum_wait_nxt;
      sum_warp_r       <= sum_warp_nxt;
      sum_excess_r     <= sum_excess_nxt;
      routes_seen_r    <= routes_seen_nxt;
    end
  end

  // Totals including the visit just evaluated.
  assign totals.total_distance        = sum_distance_f;
  assign totals.total_wait            = sum_wait_f;
  assign totals.total_time_warp       = sum_warp_f;
  assign totals.total_capacity_excess = sum_excess_f;
  assign totals.route_count           = routes_f;
  assign totals_valid                 = step && visit.solution_end;

endmodule
